/* design/rri_pkg.sv */
`default_nettype none
package rri_pkg;

	localparam int CfgIdxW = 3;
	localparam int QBits   = 32;
	localparam int NumW    = 35;
	localparam int DenW    = 33;
	localparam int AW      = NumW + 16;
	localparam int RemW    = DenW + 1;
	localparam int SqW     = 33;
	localparam logic [31:0] MinDistReset = 32'd66;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_CORNER   = 3'd0,
		CFG_EDGE_A   = 3'd1,
		CFG_EDGE_B   = 3'd2,
		CFG_NORMAL   = 3'd3,
		CFG_MIN_DIST = 3'd4
	} cfg_idx_t;

	typedef logic signed [15:0] s16_t;

	// per-item data that rides alongside the divider
	typedef struct packed {
		logic        shadow;
		logic [31:0] nearest;
		s16_t        ox, oy, oz;
		s16_t        dx, dy, dz;
		logic        miss;
		logic        sat;
	} side_t;

	typedef struct packed {
		s16_t           cx, cy, cz;
		s16_t           ax, ay, az;
		s16_t           bx, by, bz;
		s16_t           nx, ny, nz;
		logic [SqW-1:0] a_sq, b_sq;
		logic [31:0]    min_dist;
	} geom_t;

	function automatic logic [15:0] sat16(input logic signed [33:0] v);
		logic [15:0] r;
		if (v > 34'sd32767) begin
			r = 16'h7fff;
		end else if (v < -34'sd32768) begin
			r = 16'h8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* design/rri_front.sv */
`default_nettype none
module rri_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       valid_in,
	input  wire logic                       command,
	input  wire logic signed [15:0]         origin_x,
	input  wire logic signed [15:0]         origin_y,
	input  wire logic signed [15:0]         origin_z,
	input  wire logic signed [15:0]         dir_x,
	input  wire logic signed [15:0]         dir_y,
	input  wire logic signed [15:0]         dir_z,
	input  wire logic [31:0]                nearest_distance,
	input  wire rri_pkg::geom_t             geom,
	output logic                            valid_out,
	output logic [rri_pkg::AW-1:0]          a_out,
	output logic [rri_pkg::DenW-1:0]        b_out,
	output rri_pkg::side_t                  side_out
);

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	rri_pkg::side_t side_s1, side_s2, side_s3, side_s4;
	logic signed [16:0] relx_s1, rely_s1, relz_s1;
	logic signed [32:0] rnx_s2, rny_s2, rnz_s2;
	logic signed [31:0] dnx_s2, dny_s2, dnz_s2;
	logic signed [rri_pkg::NumW-1:0] num_s3;
	logic signed [rri_pkg::DenW-1:0] den_s3;
	logic [rri_pkg::AW-1:0]   a_s4;
	logic [rri_pkg::DenW-1:0] b_s4;

	logic                        num_neg, den_neg;
	logic [rri_pkg::NumW-1:0]    abs_num;
	logic [rri_pkg::DenW-1:0]    abs_den;
	rri_pkg::side_t              side_n3;

	always_comb begin
		num_neg = num_s3[rri_pkg::NumW-1];
		den_neg = den_s3[rri_pkg::DenW-1];
		abs_num = num_neg ? rri_pkg::NumW'(-num_s3) : rri_pkg::NumW'(num_s3);
		abs_den = den_neg ? rri_pkg::DenW'(-den_s3) : rri_pkg::DenW'(den_s3);
		// t <= 0 when the signs differ or the numerator is zero
		side_n3      = side_s3;
		side_n3.miss = (den_s3 == '0) || (num_s3 == '0) || (num_neg != den_neg);
		side_n3.sat  = rri_pkg::DenW'(abs_num[rri_pkg::NumW-1:16]) >= abs_den;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		side_s1.shadow  <= command;
		side_s1.nearest <= nearest_distance;
		side_s1.ox      <= origin_x;
		side_s1.oy      <= origin_y;
		side_s1.oz      <= origin_z;
		side_s1.dx      <= dir_x;
		side_s1.dy      <= dir_y;
		side_s1.dz      <= dir_z;
		side_s1.miss    <= 1'b0;
		side_s1.sat     <= 1'b0;
		relx_s1 <= 17'($signed(geom.cx)) - 17'(origin_x);
		rely_s1 <= 17'($signed(geom.cy)) - 17'(origin_y);
		relz_s1 <= 17'($signed(geom.cz)) - 17'(origin_z);

		side_s2 <= side_s1;
		rnx_s2 <= relx_s1 * $signed(geom.nx);
		rny_s2 <= rely_s1 * $signed(geom.ny);
		rnz_s2 <= relz_s1 * $signed(geom.nz);
		dnx_s2 <= $signed(side_s1.dx) * $signed(geom.nx);
		dny_s2 <= $signed(side_s1.dy) * $signed(geom.ny);
		dnz_s2 <= $signed(side_s1.dz) * $signed(geom.nz);

		side_s3 <= side_s2;
		num_s3 <= rri_pkg::NumW'(rnx_s2) + rri_pkg::NumW'(rny_s2) + rri_pkg::NumW'(rnz_s2);
		den_s3 <= rri_pkg::DenW'(dnx_s2) + rri_pkg::DenW'(dny_s2) + rri_pkg::DenW'(dnz_s2);

		side_s4 <= side_n3;
		a_s4 <= {abs_num, 16'h0000};
		b_s4 <= abs_den;
	end

	assign valid_out = valid_s4;
	assign a_out     = a_s4;
	assign b_out     = b_s4;
	assign side_out  = side_s4;

endmodule
`default_nettype wire

/* design/rri_div.sv */
`default_nettype none
module rri_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       valid_in,
	input  wire logic [rri_pkg::AW-1:0]     a_in,
	input  wire logic [rri_pkg::DenW-1:0]   b_in,
	input  wire rri_pkg::side_t             side_in,
	output logic                            valid_out,
	output logic [rri_pkg::QBits-1:0]       q_out,
	output rri_pkg::side_t                  side_out
);

	localparam int Stages = rri_pkg::QBits;

	logic [Stages:0]                 valid_s;
	logic [rri_pkg::RemW-1:0]        rem_s  [Stages+1];
	logic [rri_pkg::QBits-1:0]       q_s    [Stages+1];
	logic [rri_pkg::QBits-1:0]       alo_s  [Stages+1];
	logic [rri_pkg::DenW-1:0]        b_s    [Stages+1];
	rri_pkg::side_t                  side_s [Stages+1];

	// upper dividend bits are below the divisor unless saturated
	assign valid_s[0] = valid_in;
	assign rem_s[0]   = rri_pkg::RemW'(a_in[rri_pkg::AW-1:rri_pkg::QBits]);
	assign q_s[0]     = '0;
	assign alo_s[0]   = a_in[rri_pkg::QBits-1:0];
	assign b_s[0]     = b_in;
	assign side_s[0]  = side_in;

	for (genvar k = 0; k < Stages; k++) begin : g_stage
		logic [rri_pkg::RemW-1:0] trial;
		logic [rri_pkg::RemW-1:0] divisor;
		logic                     fits;

		always_comb begin
			trial   = {rem_s[k][rri_pkg::RemW-2:0], alo_s[k][Stages-1-k]};
			divisor = {1'b0, b_s[k]};
			fits    = trial >= divisor;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= fits ? trial - divisor : trial;
			q_s[k+1]    <= {q_s[k][rri_pkg::QBits-2:0], fits};
			alo_s[k+1]  <= alo_s[k];
			b_s[k+1]    <= b_s[k];
			side_s[k+1] <= side_s[k];
		end
	end

	assign valid_out = valid_s[Stages];
	assign q_out     = q_s[Stages];
	assign side_out  = side_s[Stages];

endmodule
`default_nettype wire

/* design/rri_back.sv */
`default_nettype none
module rri_back (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       valid_in,
	input  wire logic [rri_pkg::QBits-1:0]  q_in,
	input  wire rri_pkg::side_t             side_in,
	input  wire rri_pkg::geom_t             geom,
	output logic                            done,
	output logic                            hit,
	output logic [31:0]                     distance,
	output logic signed [15:0]              hit_x,
	output logic signed [15:0]              hit_y,
	output logic signed [15:0]              hit_z
);

	logic valid_s37, valid_s38, valid_s39, valid_s40, valid_s41, valid_s42;
	rri_pkg::side_t side_s37, side_s38, side_s39, side_s40, side_s41;
	logic [31:0] t_s37, t_s38, t_s39, t_s40, t_s41;
	logic signed [48:0] tdx_s38, tdy_s38, tdz_s38;
	logic signed [33:0] px_s39, py_s39, pz_s39;
	logic signed [33:0] px_s40, py_s40, pz_s40;
	logic signed [33:0] px_s41, py_s41, pz_s41;
	logic signed [34:0] dvx_s39, dvy_s39, dvz_s39;
	logic signed [50:0] dax_s40, day_s40, daz_s40, dbx_s40, dby_s40, dbz_s40;
	logic signed [52:0] da_s41, db_s41;
	logic [31:0] t_sel;
	rri_pkg::side_t side_n37;
	logic signed [33:0] px_c, py_c, pz_c;
	logic in_a, in_b, near_ok;

	always_comb begin
		t_sel = side_in.sat ? '1 : q_in;
		side_n37      = side_in;
		side_n37.miss = side_in.miss || (t_sel <= geom.min_dist);
		px_c = 34'($signed(side_s38.ox)) + 34'(tdx_s38 >>> 16);
		py_c = 34'($signed(side_s38.oy)) + 34'(tdy_s38 >>> 16);
		pz_c = 34'($signed(side_s38.oz)) + 34'(tdz_s38 >>> 16);
		in_a = (da_s41 >= 53'sd0) && (da_s41 <= $signed({20'b0, geom.a_sq}));
		in_b = (db_s41 >= 53'sd0) && (db_s41 <= $signed({20'b0, geom.b_sq}));
		near_ok = side_s41.shadow || (t_s41 <= side_s41.nearest);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s37 <= 1'b0;
			valid_s38 <= 1'b0;
			valid_s39 <= 1'b0;
			valid_s40 <= 1'b0;
			valid_s41 <= 1'b0;
			valid_s42 <= 1'b0;
		end else begin
			valid_s37 <= valid_in;
			valid_s38 <= valid_s37;
			valid_s39 <= valid_s38;
			valid_s40 <= valid_s39;
			valid_s41 <= valid_s40;
			valid_s42 <= valid_s41;
		end
	end

	always_ff @(posedge clk) begin
		t_s37    <= t_sel;
		side_s37 <= side_n37;

		t_s38    <= t_s37;
		side_s38 <= side_s37;
		tdx_s38  <= $signed({1'b0, t_s37}) * $signed(side_s37.dx);
		tdy_s38  <= $signed({1'b0, t_s37}) * $signed(side_s37.dy);
		tdz_s38  <= $signed({1'b0, t_s37}) * $signed(side_s37.dz);

		t_s39    <= t_s38;
		side_s39 <= side_s38;
		px_s39   <= px_c;
		py_s39   <= py_c;
		pz_s39   <= pz_c;
		dvx_s39  <= 35'(px_c) - 35'($signed(geom.cx));
		dvy_s39  <= 35'(py_c) - 35'($signed(geom.cy));
		dvz_s39  <= 35'(pz_c) - 35'($signed(geom.cz));

		t_s40    <= t_s39;
		side_s40 <= side_s39;
		px_s40   <= px_s39;
		py_s40   <= py_s39;
		pz_s40   <= pz_s39;
		dax_s40  <= dvx_s39 * $signed(geom.ax);
		day_s40  <= dvy_s39 * $signed(geom.ay);
		daz_s40  <= dvz_s39 * $signed(geom.az);
		dbx_s40  <= dvx_s39 * $signed(geom.bx);
		dby_s40  <= dvy_s39 * $signed(geom.by);
		dbz_s40  <= dvz_s39 * $signed(geom.bz);

		t_s41    <= t_s40;
		side_s41 <= side_s40;
		px_s41   <= px_s40;
		py_s41   <= py_s40;
		pz_s41   <= pz_s40;
		da_s41   <= 53'(dax_s40) + 53'(day_s40) + 53'(daz_s40);
		db_s41   <= 53'(dbx_s40) + 53'(dby_s40) + 53'(dbz_s40);

		if (!side_s41.miss && in_a && in_b && near_ok) begin
			hit      <= 1'b1;
			distance <= t_s41;
			hit_x    <= rri_pkg::sat16(px_s41);
			hit_y    <= rri_pkg::sat16(py_s41);
			hit_z    <= rri_pkg::sat16(pz_s41);
		end else begin
			hit      <= 1'b0;
			distance <= '0;
			hit_x    <= '0;
			hit_y    <= '0;
			hit_z    <= '0;
		end
	end

	assign done = valid_s42;

endmodule
`default_nettype wire

/* design/ray_rectangle_intersect_top.sv */
`default_nettype none
// Ray against rectangle intersection, fixed point, fully pipelined.
// Input channel: present a ray on command/origin_*/dir_*/nearest_distance
// with start high; it is taken at any edge where start is high and busy
// is low. busy stays low, so a new ray may enter every cycle.
// Result channel: one result per ray, in order, on hit/distance/hit_*,
// valid for exactly one cycle while done is high. The receiver cannot
// stall; results are never held.
// Throughput: one ray per cycle. The 32-stage restoring divider (one
// quotient bit per stage) sets the depth.
// Config: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Write only while no ray is in flight; edge lengths squared
// settle after a write via per-axis square registers, then sum registers.
// Reset: clears all pipeline valid bits and loads the register defaults
// (geometry zero, min_distance 66); no results appear until rays enter.
module ray_rectangle_intersect_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic                            command,
	input  wire logic signed [15:0]              origin_x,
	input  wire logic signed [15:0]              origin_y,
	input  wire logic signed [15:0]              origin_z,
	input  wire logic signed [15:0]              dir_x,
	input  wire logic signed [15:0]              dir_y,
	input  wire logic signed [15:0]              dir_z,
	input  wire logic [31:0]                     nearest_distance,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [rri_pkg::CfgIdxW-1:0]     cfg_index,
	input  wire logic [47:0]                     cfg_data,
	output logic                                 done,
	output logic                                 hit,
	output logic [31:0]                          distance,
	output logic signed [15:0]                   hit_x,
	output logic signed [15:0]                   hit_y,
	output logic signed [15:0]                   hit_z
);

	logic [47:0] corner_q, edge_a_q, edge_b_q, normal_q;
	logic [31:0] min_dist_q;
	logic [31:0] sqa0_q, sqa1_q, sqa2_q, sqb0_q, sqb1_q, sqb2_q;
	logic [rri_pkg::SqW-1:0] a_sq_q, b_sq_q;
	rri_pkg::geom_t geom;

	logic                        f_valid;
	logic [rri_pkg::AW-1:0]      f_a;
	logic [rri_pkg::DenW-1:0]    f_b;
	rri_pkg::side_t              f_side;
	logic                        d_valid;
	logic [rri_pkg::QBits-1:0]   d_q;
	rri_pkg::side_t              d_side;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_q   <= '0;
			edge_a_q   <= '0;
			edge_b_q   <= '0;
			normal_q   <= '0;
			min_dist_q <= rri_pkg::MinDistReset;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rri_pkg::CFG_CORNER:   corner_q   <= cfg_data;
				rri_pkg::CFG_EDGE_A:   edge_a_q   <= cfg_data;
				rri_pkg::CFG_EDGE_B:   edge_b_q   <= cfg_data;
				rri_pkg::CFG_NORMAL:   normal_q   <= cfg_data;
				rri_pkg::CFG_MIN_DIST: min_dist_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// squared edge lengths, derived from the edge registers
	always_ff @(posedge clk) begin
		sqa0_q <= 32'($signed(edge_a_q[15:0])  * $signed(edge_a_q[15:0]));
		sqa1_q <= 32'($signed(edge_a_q[31:16]) * $signed(edge_a_q[31:16]));
		sqa2_q <= 32'($signed(edge_a_q[47:32]) * $signed(edge_a_q[47:32]));
		sqb0_q <= 32'($signed(edge_b_q[15:0])  * $signed(edge_b_q[15:0]));
		sqb1_q <= 32'($signed(edge_b_q[31:16]) * $signed(edge_b_q[31:16]));
		sqb2_q <= 32'($signed(edge_b_q[47:32]) * $signed(edge_b_q[47:32]));
		a_sq_q <= rri_pkg::SqW'(sqa0_q) + rri_pkg::SqW'(sqa1_q) + rri_pkg::SqW'(sqa2_q);
		b_sq_q <= rri_pkg::SqW'(sqb0_q) + rri_pkg::SqW'(sqb1_q) + rri_pkg::SqW'(sqb2_q);
	end

	always_comb begin
		geom.cx = corner_q[15:0];
		geom.cy = corner_q[31:16];
		geom.cz = corner_q[47:32];
		geom.ax = edge_a_q[15:0];
		geom.ay = edge_a_q[31:16];
		geom.az = edge_a_q[47:32];
		geom.bx = edge_b_q[15:0];
		geom.by = edge_b_q[31:16];
		geom.bz = edge_b_q[47:32];
		geom.nx = normal_q[15:0];
		geom.ny = normal_q[31:16];
		geom.nz = normal_q[47:32];
		geom.a_sq = a_sq_q;
		geom.b_sq = b_sq_q;
		geom.min_dist = min_dist_q;
	end

	rri_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.valid_in         (start && !busy),
		.command          (command),
		.origin_x         (origin_x),
		.origin_y         (origin_y),
		.origin_z         (origin_z),
		.dir_x            (dir_x),
		.dir_y            (dir_y),
		.dir_z            (dir_z),
		.nearest_distance (nearest_distance),
		.geom             (geom),
		.valid_out        (f_valid),
		.a_out            (f_a),
		.b_out            (f_b),
		.side_out         (f_side)
	);

	rri_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (f_valid),
		.a_in      (f_a),
		.b_in      (f_b),
		.side_in   (f_side),
		.valid_out (d_valid),
		.q_out     (d_q),
		.side_out  (d_side)
	);

	rri_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_in (d_valid),
		.q_in     (d_q),
		.side_in  (d_side),
		.geom     (geom),
		.done     (done),
		.hit      (hit),
		.distance (distance),
		.hit_x    (hit_x),
		.hit_y    (hit_y),
		.hit_z    (hit_z)
	);

endmodule
`default_nettype wire
